// ===== src/fqps_pkg.sv =====
package fqps_pkg;

  localparam int unsigned TagW  = 16;
  localparam int unsigned FlowW = 3;
  localparam int unsigned StatW = 3;
  localparam int unsigned LaneW = 16;
  localparam int unsigned CfgW  = 64;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [StatW-1:0] StAccepted = 3'd0;
  localparam logic [StatW-1:0] StDropped  = 3'd1;
  localparam logic [StatW-1:0] StDequeued = 3'd2;
  localparam logic [StatW-1:0] StEmpty    = 3'd3;
  localparam logic [StatW-1:0] StFull     = 3'd4;

  localparam logic [CfgIdxW-1:0] RegWeightsLo = 2'd0;
  localparam logic [CfgIdxW-1:0] RegWeightsHi = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBurstsLo  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegBurstsHi  = 2'd3;

  localparam logic [CfgW-1:0] WeightsLoReset = 64'h0002_0002_0002_0002;
  localparam logic [CfgW-1:0] WeightsHiReset = 64'h0000_00C8_0014_0014;
  localparam logic [CfgW-1:0] BurstsLoReset  = 64'h0064_0064_0064_0064;
  localparam logic [CfgW-1:0] BurstsHiReset  = 64'h0000_03E8_03E8_03E8;

  localparam logic OpEnqueue = 1'b0;
  localparam logic OpDequeue = 1'b1;

  typedef struct packed {
    logic load;        // latch a new transaction
    logic calc_emit;   // report an immediate result (empty, drop, full)
    logic begin_ins;   // commit flow state and start the insertion walk
    logic step;        // move one entry up by one slot
    logic finish_ins;  // write the new entry and report acceptance
    logic rd_head;     // read the head entry
    logic deq_done;    // report the dequeued entry and pop it
  } fqps_cmd_t;

  typedef struct packed {
    logic is_deq;
    logic empty;
    logic pass;        // enqueue that goes into the store
    logic pos_zero;
    logic greater;     // entry read is later than the new one
  } fqps_stat_t;

endpackage

// ===== src/fqps_ram.sv =====
module fqps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== src/fqps_datapath.sv =====
module fqps_datapath #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned NUM_FLOWS   = 8,
  parameter int unsigned ROUND_BITS  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fqps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fqps_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         operation_i,
  input  logic [fqps_pkg::FlowW-1:0]   flow_id_i,
  input  logic [fqps_pkg::TagW-1:0]    packet_tag_i,
  input  fqps_pkg::fqps_cmd_t          cmd_i,
  output fqps_pkg::fqps_stat_t         stat_o,
  output logic                         done_o,
  output logic [fqps_pkg::StatW-1:0]   status_o,
  output logic [fqps_pkg::TagW-1:0]    out_tag_o,
  output logic [fqps_pkg::FlowW-1:0]   out_flow_o,
  output logic [ROUND_BITS-1:0]        finish_round_o
);
  import fqps_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DW = ROUND_BITS + LaneW + 1;
  localparam int unsigned EW = ROUND_BITS + TagW + FlowW;
  localparam logic [AW-1:0] LastSlot = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);

  logic [CfgW-1:0] wlo_q, whi_q, blo_q, bhi_q;
  logic [ROUND_BITS-1:0] cur_q;
  logic [ROUND_BITS-1:0] last_q [NUM_FLOWS];
  logic [AW-1:0] head_q, tail_q, ptr_q;
  logic [CW-1:0] count_q, pos_q;
  logic op_q;
  logic [FlowW-1:0] flow_q;
  logic [TagW-1:0] tag_q;
  logic [ROUND_BITS-1:0] fin_q;
  logic done_q;
  logic [StatW-1:0] status_q;
  logic [TagW-1:0] otag_q;
  logic [FlowW-1:0] oflow_q;
  logic [ROUND_BITS-1:0] ofin_q;

  logic [LaneW-1:0] w_c, b_c;
  logic [CfgW-1:0] wreg_c, breg_c;
  logic [ROUND_BITS-1:0] last_c, start_c, fin_c;
  logic [DW-1:0] dist_c, sum_c;
  logic flow_bad_c, drop_c, full_c;
  logic [AW-1:0] prev_ptr_c, raddr_c, waddr_c;
  logic we_c;
  logic [EW-1:0] wdata_c, rdata_c;
  logic [ROUND_BITS-1:0] rd_fin_c;

  // Flow weight and burst lanes.
  always_comb begin
    wreg_c = flow_q[2] ? whi_q : wlo_q;
    breg_c = flow_q[2] ? bhi_q : blo_q;
    w_c = LaneW'(wreg_c >> (LaneW * flow_q[1:0]));
    b_c = LaneW'(breg_c >> (LaneW * flow_q[1:0]));
  end

  always_comb begin
    last_c = '0;
    for (int i = 0; i < NUM_FLOWS; i++) begin
      if (int'(flow_q) == i) last_c = last_q[i];
    end
  end

  assign start_c    = (last_c > cur_q) ? last_c : cur_q;
  assign dist_c     = DW'(start_c - cur_q) + DW'(w_c);
  assign sum_c      = DW'(start_c) + DW'(w_c);
  assign fin_c      = sum_c[ROUND_BITS-1:0];
  assign flow_bad_c = int'(flow_q) >= NUM_FLOWS;
  assign drop_c     = flow_bad_c || (dist_c >= DW'(b_c));
  assign full_c     = count_q == FullCount;

  assign rd_fin_c = rdata_c[EW-1 -: ROUND_BITS];

  assign stat_o.is_deq   = op_q == OpDequeue;
  assign stat_o.empty    = count_q == '0;
  assign stat_o.pass     = !drop_c && !full_c;
  assign stat_o.pos_zero = pos_q == '0;
  assign stat_o.greater  = rd_fin_c > fin_q;

  assign prev_ptr_c = (ptr_q == '0) ? LastSlot : ptr_q - AW'(1);
  assign raddr_c    = cmd_i.rd_head ? head_q : prev_ptr_c;
  assign waddr_c    = ptr_q;
  assign we_c       = cmd_i.step || cmd_i.finish_ins;
  assign wdata_c    = cmd_i.step ? rdata_c : {fin_q, tag_q, flow_q};

  fqps_ram #(.Width(EW), .Depth(QUEUE_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .waddr_i (waddr_c),
    .wdata_i (wdata_c),
    .raddr_i (raddr_c),
    .rdata_o (rdata_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlo_q <= WeightsLoReset;
      whi_q <= WeightsHiReset;
      blo_q <= BurstsLoReset;
      bhi_q <= BurstsHiReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegWeightsLo: wlo_q <= cfg_data_i;
        RegWeightsHi: whi_q <= cfg_data_i;
        RegBurstsLo:  blo_q <= cfg_data_i;
        RegBurstsHi:  bhi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < NUM_FLOWS; i++) last_q[i] <= '0;
    end else begin
      done_q <= cmd_i.calc_emit || cmd_i.finish_ins || cmd_i.deq_done;
      if (cmd_i.begin_ins) begin
        for (int i = 0; i < NUM_FLOWS; i++) begin
          if (int'(flow_q) == i) last_q[i] <= fin_c;
        end
      end
      if (cmd_i.finish_ins) begin
        tail_q  <= (tail_q == LastSlot) ? '0 : tail_q + AW'(1);
        count_q <= count_q + CW'(1);
      end
      if (cmd_i.deq_done) begin
        head_q  <= (head_q == LastSlot) ? '0 : head_q + AW'(1);
        count_q <= count_q - CW'(1);
        cur_q   <= rd_fin_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      flow_q <= flow_id_i;
      tag_q  <= packet_tag_i;
    end
    if (cmd_i.begin_ins) begin
      fin_q <= fin_c;
      ptr_q <= tail_q;
      pos_q <= count_q;
    end
    if (cmd_i.step) begin
      ptr_q <= prev_ptr_c;
      pos_q <= pos_q - CW'(1);
    end
    if (cmd_i.calc_emit) begin
      if (op_q == OpDequeue) begin
        status_q <= StEmpty;
        otag_q   <= '0;
        oflow_q  <= '0;
        ofin_q   <= '0;
      end else begin
        status_q <= drop_c ? StDropped : StFull;
        otag_q   <= tag_q;
        oflow_q  <= flow_q;
        ofin_q   <= flow_bad_c ? '0 : fin_c;
      end
    end
    if (cmd_i.finish_ins) begin
      status_q <= StAccepted;
      otag_q   <= tag_q;
      oflow_q  <= flow_q;
      ofin_q   <= fin_q;
    end
    if (cmd_i.deq_done) begin
      status_q <= StDequeued;
      otag_q   <= rdata_c[FlowW +: TagW];
      oflow_q  <= rdata_c[FlowW-1:0];
      ofin_q   <= rd_fin_c;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_tag_o      = otag_q;
  assign out_flow_o     = oflow_q;
  assign finish_round_o = ofin_q;

endmodule

// ===== src/fqps_ctrl.sv =====
module fqps_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  fqps_pkg::fqps_stat_t stat_i,
  output fqps_pkg::fqps_cmd_t  cmd_o
);
  import fqps_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SCalc = 3'd1;
  localparam logic [2:0] SRead = 3'd2;
  localparam logic [2:0] SCmp  = 3'd3;
  localparam logic [2:0] SDeq  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = SCalc;
        end
      end
      SCalc: begin
        if (stat_i.is_deq && !stat_i.empty) begin
          cmd_o.rd_head = 1'b1;
          state_d = SDeq;
        end else if (!stat_i.is_deq && stat_i.pass) begin
          cmd_o.begin_ins = 1'b1;
          state_d = SRead;
        end else begin
          cmd_o.calc_emit = 1'b1;
          state_d = SIdle;
        end
      end
      SRead: begin
        if (stat_i.pos_zero) begin
          cmd_o.finish_ins = 1'b1;
          state_d = SIdle;
        end else begin
          state_d = SCmp;
        end
      end
      SCmp: begin
        if (stat_i.greater) begin
          cmd_o.step = 1'b1;
          state_d = SRead;
        end else begin
          cmd_o.finish_ins = 1'b1;
          state_d = SIdle;
        end
      end
      SDeq: begin
        cmd_o.deq_done = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = state_q != SIdle;

endmodule

// ===== src/fair_queue_pifo_scheduler.sv =====
// Sequence (start taken to result): a rejected enqueue or empty dequeue is answered from the
//   evaluate state, a dequeue after a head read, and an accepted enqueue after a walk that
//   moves each stored entry later than it up by one slot.
// Throughput: one transaction at a time; the insertion walk over the RAM
//   read port, one compare per stored entry that it visits, sets the enqueue time.
// Reset: asynchronous, active low; clears round, flow state and count and loads defaults.
module fair_queue_pifo_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 64,
  parameter int unsigned NUM_FLOWS   = 8,
  parameter int unsigned ROUND_BITS  = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fqps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [fqps_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         operation_i,
  input  logic [fqps_pkg::FlowW-1:0]   flow_id_i,
  input  logic [fqps_pkg::TagW-1:0]    packet_tag_i,
  output logic                         done_o,
  output logic [fqps_pkg::StatW-1:0]   status_o,
  output logic [fqps_pkg::TagW-1:0]    out_tag_o,
  output logic [fqps_pkg::FlowW-1:0]   out_flow_o,
  output logic [ROUND_BITS-1:0]        finish_round_o
);
  import fqps_pkg::*;

  fqps_cmd_t  cmd;
  fqps_stat_t stat;

  // Sequence each transaction: latch, evaluate, then walk or pop.
  fqps_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // Hold rounds, flow state and the circular sorted store.
  fqps_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .NUM_FLOWS   (NUM_FLOWS),
    .ROUND_BITS  (ROUND_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .operation_i    (operation_i),
    .flow_id_i      (flow_id_i),
    .packet_tag_i   (packet_tag_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_tag_o      (out_tag_o),
    .out_flow_o     (out_flow_o),
    .finish_round_o (finish_round_o)
  );

endmodule

// ===== verif/fair_queue_pifo_scheduler_tb.sv =====
`timescale 1ns / 100ps

module fair_queue_pifo_scheduler_tb;
  import fqps_pkg::*;

  localparam int unsigned Depth = 64;
  localparam int unsigned Flows = 8;
  localparam int unsigned RoundW = 32;

  typedef struct packed {
    logic              op;
    logic [FlowW-1:0]  flow;
    logic [TagW-1:0]   tag;
  } pkt_cmd_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [TagW-1:0]   tag;
    logic [FlowW-1:0]  flow;
    logic [RoundW-1:0] fin;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = RegWeightsLo;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic operation_i = OpEnqueue;
  logic [FlowW-1:0] flow_id_i = '0;
  logic [TagW-1:0] packet_tag_i = '0;
  logic done_o;
  logic [StatW-1:0] status_o;
  logic [TagW-1:0] out_tag_o;
  logic [FlowW-1:0] out_flow_o;
  logic [RoundW-1:0] finish_round_o;

  fair_queue_pifo_scheduler uut (.*);

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Scheduler shadow state
  logic [CfgW-1:0] wt_lo, wt_hi, bu_lo, bu_hi;
  logic [RoundW-1:0] cur_round;
  logic [RoundW-1:0] flow_last [Flows];
  sched_result_t sorted_pkts [$];

  pkt_cmd_t pending_cmds [$];
  sched_result_t expected_results [$];
  int unsigned error_count = 0;
  int unsigned sender_idle_pct = 0;

  task automatic report_mismatch(input string what);
    $display("%0t ns: MISMATCH %s", $time, what);
    error_count++;
  endtask

  function automatic logic [15:0] lane_of(input logic [CfgW-1:0] lo, hi, input int f);
    logic [CfgW-1:0] r;
    r = (f < 4) ? lo : hi;
    return r[16*(f%4) +: 16];
  endfunction

  // Compute the reply for one transaction and update the shadow state
  function automatic sched_result_t schedule_packet(input pkt_cmd_t c);
    sched_result_t r;
    logic [63:0] w, b, gap;
    logic [RoundW-1:0] start, fin;
    int pos;
    r = '0;
    if (c.op == OpDequeue) begin
      if (sorted_pkts.size() == 0) begin
        r.status = StEmpty;
        return r;
      end
      r = sorted_pkts.pop_front();
      r.status = StDequeued;
      cur_round = r.fin;
      return r;
    end
    r.tag = c.tag;
    r.flow = c.flow;
    w = 64'(lane_of(wt_lo, wt_hi, c.flow));
    b = 64'(lane_of(bu_lo, bu_hi, c.flow));
    start = (flow_last[c.flow] > cur_round) ? flow_last[c.flow] : cur_round;
    gap = 64'(start - cur_round) + w;
    fin = RoundW'(64'(start) + w);
    r.fin = fin;
    if (gap >= b) begin
      r.status = StDropped;
      return r;
    end
    if (sorted_pkts.size() >= Depth) begin
      r.status = StFull;
      return r;
    end
    flow_last[c.flow] = fin;
    r.status = StAccepted;
    // insert after every entry with an equal or smaller finish round
    pos = sorted_pkts.size();
    while (pos > 0 && sorted_pkts[pos-1].fin > fin) pos--;
    sorted_pkts.insert(pos, r);
    return r;
  endfunction

  // Flag the rising edge that took the transaction
  logic accepted_now = 1'b0;
  always @(posedge clk_i) accepted_now <= rst_ni && start_i && !busy_o;

  // Drive at falling edge: hold start until the block takes it
  bit in_flight = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_flight || accepted_now) begin
        if (pending_cmds.size() > 0 && !cfg_we_i &&
            $urandom_range(99, 0) >= sender_idle_pct) begin
          pkt_cmd_t c;
          c = pending_cmds.pop_front();
          expected_results.insert(expected_results.size(), schedule_packet(c));
          operation_i <= c.op;
          flow_id_i <= c.flow;
          packet_tag_i <= c.tag;
          start_i <= 1'b1;
          in_flight = 1'b1;
        end else begin
          start_i <= 1'b0;
          in_flight = 1'b0;
        end
      end
    end
  end

  // Monitor: check results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result status %0d", status_o));
        end else begin
          sched_result_t e;
          e = expected_results.pop_front();
          if (status_o !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", status_o, e.status));
          if (out_tag_o !== e.tag)
            report_mismatch($sformatf("tag %h, want %h", out_tag_o, e.tag));
          if (out_flow_o !== e.flow)
            report_mismatch($sformatf("flow %0d, want %0d", out_flow_o, e.flow));
          if (finish_round_o !== e.fin)
            report_mismatch($sformatf("finish %0d, want %0d", finish_round_o, e.fin));
        end
      end
    end
  end

  // Wait until every queued transaction has been taken and answered
  task automatic drain();
    while (pending_cmds.size() > 0 || in_flight || expected_results.size() > 0)
      @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      RegWeightsLo: wt_lo = val;
      RegWeightsHi: wt_hi = val;
      RegBurstsLo:  bu_lo = val;
      default:      bu_hi = val;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_cmd(input logic op, input int f, input int t);
    pkt_cmd_t c;
    c.op = op;
    c.flow = FlowW'(f);
    c.tag = TagW'(t);
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  // Mostly enqueues so the store fills; dequeues keep rounds moving
  task automatic random_burst(input int n, input int deq_pct);
    repeat (n)
      push_cmd($urandom_range(99, 0) < deq_pct ? OpDequeue : OpEnqueue,
               $urandom_range(Flows-1, 0), $urandom_range(16'hFFFF, 0));
  endtask

  task automatic random_cfg(input int wmax, input int bmax);
    logic [CfgW-1:0] v [4];
    foreach (v[i])
      for (int l = 0; l < 4; l++)
        v[i][16*l +: 16] = (i < 2) ? 16'($urandom_range(wmax, 0)) :
                                     16'($urandom_range(bmax, 0));
    write_reg(RegWeightsLo, v[0]);
    write_reg(RegWeightsHi, v[1]);
    write_reg(RegBurstsLo, v[2]);
    write_reg(RegBurstsHi, v[3]);
  endtask

  initial begin
    wt_lo = WeightsLoReset;
    wt_hi = WeightsHiReset;
    bu_lo = BurstsLoReset;
    bu_hi = BurstsHiReset;
    cur_round = '0;
    foreach (flow_last[i]) flow_last[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty dequeue, tag extremes, equal rounds, drops, zero burst
    push_cmd(OpDequeue, 7, 16'hFFFF);
    push_cmd(OpEnqueue, 0, 16'h0000);
    push_cmd(OpEnqueue, 1, 16'hFFFF);
    push_cmd(OpEnqueue, 2, 16'h5555);
    push_cmd(OpEnqueue, 4, 16'hAAAA);
    push_cmd(OpEnqueue, 6, 16'h1234);
    push_cmd(OpEnqueue, 7, 16'h4321);
    push_cmd(OpEnqueue, 6, 16'h0F0F);
    repeat (6) push_cmd(OpDequeue, 0, 0);
    push_cmd(OpDequeue, 0, 0);
    for (int i = 0; i < 8; i++) push_cmd(OpEnqueue, 0, i);
    drain();

    // Store full: large bursts, small weights, 70 enqueues
    write_reg(RegBurstsLo, '1);
    write_reg(RegBurstsHi, '1);
    write_reg(RegWeightsLo, '0);
    write_reg(RegWeightsHi, 64'h0001_0001_0001_0001);
    for (int i = 0; i < 70; i++) push_cmd(OpEnqueue, i % 8, $urandom_range(16'hFFFF, 0));
    repeat (70) push_cmd(OpDequeue, 0, 0);
    drain();

    // Maximum weights under maximum bursts, then zero bursts
    write_reg(RegWeightsLo, '1);
    write_reg(RegWeightsHi, '1);
    random_burst(40, 40);
    write_reg(RegBurstsLo, '0);
    write_reg(RegBurstsHi, '0);
    random_burst(20, 30);

    // Random phases with varying sender idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 57;
        2: sender_idle_pct = 6;
        default: sender_idle_pct = 0;
      endcase
      random_cfg(ph < 4 ? 8 : 16'hFFFF, ph < 4 ? 200 : 16'hFFFF);
      random_burst(180, (ph % 2) ? 45 : 30);
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
src/fqps_pkg.sv
src/fqps_ram.sv
src/fqps_datapath.sv
src/fqps_ctrl.sv
src/fair_queue_pifo_scheduler.sv
verif/fair_queue_pifo_scheduler_tb.sv
